// ===== hw/rtl/at_command_frame_builder_macros.svh =====
// ----------------------------------------------------------------------------
// AT command frame builder assertion macros
// Shared assertion shorthands, clocked on clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef AT_COMMAND_FRAME_BUILDER_MACROS_SVH
`define AT_COMMAND_FRAME_BUILDER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ATCFB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define ATCFB_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hw/rtl/atcfb_pkg.sv =====
// ----------------------------------------------------------------------------
// AT command frame builder package
// Shared constants, the work item passed between front and back, and helpers.
// ----------------------------------------------------------------------------
package atcfb_pkg;

    localparam logic [7:0] API_ID_AT   = 8'h08;
    localparam logic [6:0] ID_FIRST    = 7'h41;
    localparam logic [6:0] ID_LAST     = 7'h5A;
    localparam logic [7:0] DELIM_RESET = 8'h7E;
    localparam logic [7:0] CSUM_BASE   = 8'hFF;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_IDX_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // One classified input byte, with everything the back end needs to emit it.
    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [15:0] dlen;
        logic [6:0]  fid;
        logic [7:0]  csum;
    } item_t;

    typedef enum logic [6:0] {
        ST_DELIM   = 7'b0000001,
        ST_LEN_HI  = 7'b0000010,
        ST_LEN_LO  = 7'b0000100,
        ST_API     = 7'b0001000,
        ST_FID     = 7'b0010000,
        ST_PAYLOAD = 7'b0100000,
        ST_CSUM    = 7'b1000000
    } back_state_t;

    // Rolling frame id: A through Z, then back to A. Anything out of range restarts at A.
    function automatic logic [6:0] next_id(input logic [6:0] id);
        logic [6:0] res;
        if (id < ID_FIRST || id >= ID_LAST)
            res = ID_FIRST;
        else
            res = id + 7'd1;
        return res;
    endfunction

endpackage

// ===== hw/rtl/at_command_frame_builder.sv =====
// ----------------------------------------------------------------------------
// AT command frame builder
// Wraps AT command bytes into serial API frames with header and checksum.
// ----------------------------------------------------------------------------
//
// Channel     Direction  Handshake           Transaction
// input       in         push / full         one payload byte with frame marks
// result      out        empty / pop         one frame byte with run/frame ends
// config      in         cfg_write           start delimiter byte, no read-back
//
// The front end accepts one byte per cycle while the item queue has room and
// the back end sends one frame byte per cycle into the output register while
// that register is free or being popped. A plain payload byte therefore yields
// one frame byte, a first byte adds five header bytes and a last the checksum.
// The output register and the four-entry item queue keep the input side moving
// while a result waits to be popped; full rises only when the queue fills.
// Reset clears the frame id, running sum, queue and output valid; the start
// delimiter returns to 0x7E. There is no clearing pass.
// ----------------------------------------------------------------------------
module at_command_frame_builder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [7:0]  cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  payload_byte,
    input  logic        first_of_frame,
    input  logic        last_of_frame,
    input  logic [15:0] payload_length,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        run_end,
    output logic        frame_end
);

    // Start delimiter register, unguarded: write it only while the block is idle.
    logic [7:0] start_delim_reg, start_delim_next;

    // Queue between the classifying front end and the frame sequencer.
    atcfb_pkg::item_t q_item;
    atcfb_pkg::item_t q_head;
    logic             q_wr;
    logic             q_rd;
    logic             q_full;
    logic             q_nonempty;

    assign start_delim_next = cfg_write ? cfg_data : start_delim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_delim_reg <= atcfb_pkg::DELIM_RESET;
        end
        else
        begin
            start_delim_reg <= start_delim_next;
        end
    end

    // The front end updates the frame id and running sum as each transaction
    // is accepted, so the checksum is ready before the back end needs it.
    atcfb_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .payload_byte   (payload_byte),
        .first_of_frame (first_of_frame),
        .last_of_frame  (last_of_frame),
        .payload_length (payload_length),
        .q_full         (q_full),
        .q_wr           (q_wr),
        .q_item         (q_item)
    );

    atcfb_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wr_item  (q_item),
        .rd       (q_rd),
        .head     (q_head),
        .full     (q_full),
        .nonempty (q_nonempty)
    );

    // The back end walks header (first items), payload and checksum (last items)
    // steps and releases the queue entry with the item's final result byte.
    atcfb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .start_delim (start_delim_reg),
        .head        (q_head),
        .q_nonempty  (q_nonempty),
        .q_rd        (q_rd),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .run_end     (run_end),
        .frame_end   (frame_end)
    );

endmodule

// ===== hw/rtl/atcfb_fifo.sv =====
// ----------------------------------------------------------------------------
// AT command frame builder item queue
// Short queue of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module atcfb_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr,
    input  atcfb_pkg::item_t     wr_item,
    input  logic                 rd,
    output atcfb_pkg::item_t     head,
    output logic                 full,
    output logic                 nonempty
);

    atcfb_pkg::item_t mem [atcfb_pkg::FIFO_DEPTH];

    logic [atcfb_pkg::FIFO_IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [atcfb_pkg::FIFO_IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [atcfb_pkg::FIFO_CNT_W-1:0] count_reg, count_next;

    localparam logic [atcfb_pkg::FIFO_IDX_W-1:0] LAST_IDX =
        atcfb_pkg::FIFO_IDX_W'(atcfb_pkg::FIFO_DEPTH - 1);
    localparam logic [atcfb_pkg::FIFO_CNT_W-1:0] FULL_CNT =
        atcfb_pkg::FIFO_CNT_W'(atcfb_pkg::FIFO_DEPTH);

    assign full     = (count_reg == FULL_CNT);
    assign nonempty = (count_reg != '0);
    assign head     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
            count_next = count_reg + 1'b1;
        else if (!wr && rd)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/atcfb_front.sv =====
// ----------------------------------------------------------------------------
// AT command frame builder front end
// Accepts payload bytes, advances the frame id and folds each byte into the checksum.
// ----------------------------------------------------------------------------
module atcfb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        payload_byte,
    input  logic              first_of_frame,
    input  logic              last_of_frame,
    input  logic [15:0]       payload_length,
    input  logic              q_full,
    output logic              q_wr,
    output atcfb_pkg::item_t  q_item
);

    logic [6:0] frame_id_reg, frame_id_next;
    logic [7:0] sum_reg, sum_next;
    logic [6:0] id_new;
    logic [7:0] sum_base;

    assign full = q_full;
    assign q_wr = push && !q_full;

    always_comb
    begin
        id_new   = atcfb_pkg::next_id(frame_id_reg);
        sum_base = first_of_frame ? (atcfb_pkg::API_ID_AT + {1'b0, id_new}) : sum_reg;
        sum_next = sum_base + payload_byte;
        frame_id_next = first_of_frame ? id_new : frame_id_reg;

        q_item.data  = payload_byte;
        q_item.first = first_of_frame;
        q_item.last  = last_of_frame;
        q_item.dlen  = payload_length + 16'd2;
        q_item.fid   = id_new;
        q_item.csum  = atcfb_pkg::CSUM_BASE - sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_id_reg <= '0;
            sum_reg      <= '0;
        end
        else if (q_wr)
        begin
            frame_id_reg <= frame_id_next;
            sum_reg      <= sum_next;
        end
    end

endmodule

// ===== hw/rtl/atcfb_back.sv =====
// ----------------------------------------------------------------------------
// AT command frame builder back end
// Expands each item into its byte, plus header if first and checksum if last.
// ----------------------------------------------------------------------------
`include "at_command_frame_builder_macros.svh"

module atcfb_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        start_delim,
    input  atcfb_pkg::item_t  head,
    input  logic              q_nonempty,
    output logic              q_rd,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        out_byte,
    output logic              run_end,
    output logic              frame_end
);

    atcfb_pkg::back_state_t state_reg, state_next, step;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       run_end_reg, run_end_next;
    logic       frame_end_reg, frame_end_next;
    logic       load;

    assign empty     = !out_valid_reg;
    assign out_byte  = byte_reg;
    assign run_end   = run_end_reg;
    assign frame_end = frame_end_reg;

    // With an item queued, the output register loads when free or being drained.
    assign load = q_nonempty && (!out_valid_reg || pop);

    always_comb
    begin
        // An item without the first mark skips the header.
        step = (state_reg == atcfb_pkg::ST_DELIM && !head.first) ?
               atcfb_pkg::ST_PAYLOAD : state_reg;

        state_next     = state_reg;
        byte_next      = byte_reg;
        run_end_next   = run_end_reg;
        frame_end_next = frame_end_reg;
        q_rd           = 1'b0;

        if (load)
        begin
            run_end_next   = 1'b0;
            frame_end_next = 1'b0;
            unique case (step)
                atcfb_pkg::ST_DELIM:
                begin
                    byte_next  = start_delim;
                    state_next = atcfb_pkg::ST_LEN_HI;
                end
                atcfb_pkg::ST_LEN_HI:
                begin
                    byte_next  = head.dlen[15:8];
                    state_next = atcfb_pkg::ST_LEN_LO;
                end
                atcfb_pkg::ST_LEN_LO:
                begin
                    byte_next  = head.dlen[7:0];
                    state_next = atcfb_pkg::ST_API;
                end
                atcfb_pkg::ST_API:
                begin
                    byte_next  = atcfb_pkg::API_ID_AT;
                    state_next = atcfb_pkg::ST_FID;
                end
                atcfb_pkg::ST_FID:
                begin
                    byte_next  = {1'b0, head.fid};
                    state_next = atcfb_pkg::ST_PAYLOAD;
                end
                atcfb_pkg::ST_PAYLOAD:
                begin
                    byte_next = head.data;
                    if (head.last)
                    begin
                        state_next = atcfb_pkg::ST_CSUM;
                    end
                    else
                    begin
                        run_end_next = 1'b1;
                        q_rd         = 1'b1;
                        state_next   = atcfb_pkg::ST_DELIM;
                    end
                end
                atcfb_pkg::ST_CSUM:
                begin
                    byte_next      = head.csum;
                    run_end_next   = 1'b1;
                    frame_end_next = 1'b1;
                    q_rd           = 1'b1;
                    state_next     = atcfb_pkg::ST_DELIM;
                end
                default:
                begin
                    state_next = atcfb_pkg::ST_DELIM;
                end
            endcase
        end

        if (load)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= atcfb_pkg::ST_DELIM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        run_end_reg   <= run_end_next;
        frame_end_reg <= frame_end_next;
    end

    `ATCFB_ASSERT(a_csum_closes_run, (out_valid_reg && frame_end_reg) |-> run_end_reg, "checksum byte must close its run")
    `ATCFB_ASSERT(a_rd_only_at_end, q_rd |-> (step == atcfb_pkg::ST_PAYLOAD || step == atcfb_pkg::ST_CSUM), "queue read outside payload or checksum step")
    `ATCFB_ASSERT_NEXT(a_csum_restarts, load && step == atcfb_pkg::ST_CSUM, state_reg == atcfb_pkg::ST_DELIM, "sequencer did not return to frame start after checksum")

endmodule

// ===== tb/at_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AT frame checker
// Watches the input, result and configuration channels of the frame builder.
// It predicts every frame byte that an accepted payload byte should produce,
// then compares each popped byte with the oldest prediction.
// ----------------------------------------------------------------------------
module at_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [7:0]  cfg_data,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  payload_byte,
    input  logic        first_of_frame,
    input  logic        last_of_frame,
    input  logic [15:0] payload_length,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  out_byte,
    input  logic        run_end,
    input  logic        frame_end,
    output int          fail_count,
    output int          pending,
    output int          bytes_in,
    output int          bytes_out,
    output int          checksums
);

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       frame_end;
    } frame_byte_t;

    frame_byte_t frame_bytes_due[$];
    frame_byte_t want;

    // Predicted state of the block.
    logic [7:0] delimiter;
    logic [6:0] frame_id;
    logic [7:0] running_sum;

    function automatic frame_byte_t fbyte(input logic [7:0] d, input logic re, input logic fe);
        frame_byte_t fb;
        fb.data      = d;
        fb.run_end   = re;
        fb.frame_end = fe;
        return fb;
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("%0t ns: frame byte %0d: %s", $time, bytes_out, what);
    endtask

    // Appends every frame byte that one accepted payload byte causes.
    task automatic predict_frame_bytes(input logic [7:0] b, input logic first,
                                       input logic last, input logic [15:0] len);
        logic [15:0] wire_len;
        wire_len = len + 16'd2;
        if (first)
        begin
            if (frame_id < atcfb_pkg::ID_FIRST || frame_id >= atcfb_pkg::ID_LAST)
                frame_id = atcfb_pkg::ID_FIRST;
            else
                frame_id = frame_id + 7'd1;
            frame_bytes_due.push_back(fbyte(delimiter, 1'b0, 1'b0));
            frame_bytes_due.push_back(fbyte(wire_len[15:8], 1'b0, 1'b0));
            frame_bytes_due.push_back(fbyte(wire_len[7:0], 1'b0, 1'b0));
            frame_bytes_due.push_back(fbyte(atcfb_pkg::API_ID_AT, 1'b0, 1'b0));
            frame_bytes_due.push_back(fbyte({1'b0, frame_id}, 1'b0, 1'b0));
            running_sum = atcfb_pkg::API_ID_AT + {1'b0, frame_id};
        end
        running_sum = running_sum + b;
        frame_bytes_due.push_back(fbyte(b, !last, 1'b0));
        if (last)
            frame_bytes_due.push_back(fbyte(atcfb_pkg::CSUM_BASE - running_sum,
                                            1'b1, 1'b1));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_bytes_due.delete();
            delimiter   = atcfb_pkg::DELIM_RESET;
            frame_id    = '0;
            running_sum = '0;
            fail_count  = 0;
            bytes_in    = 0;
            bytes_out   = 0;
            checksums   = 0;
        end
        else
        begin
            if (cfg_write)
                delimiter = cfg_data;

            if (pop && !empty)
            begin
                if (frame_bytes_due.size() == 0)
                    report_mismatch($sformatf("unexpected byte 0x%02h", out_byte));
                else
                begin
                    want = frame_bytes_due.pop_front();
                    if (out_byte !== want.data)
                        report_mismatch($sformatf("out_byte expected 0x%02h, got 0x%02h",
                                                  want.data, out_byte));
                    if (run_end !== want.run_end)
                        report_mismatch($sformatf("run_end expected %b, got %b",
                                                  want.run_end, run_end));
                    if (frame_end !== want.frame_end)
                        report_mismatch($sformatf("frame_end expected %b, got %b",
                                                  want.frame_end, frame_end));
                    if (want.frame_end)
                        checksums++;
                end
                bytes_out++;
            end

            if (push && !full)
            begin
                predict_frame_bytes(payload_byte, first_of_frame, last_of_frame,
                                    payload_length);
                bytes_in++;
            end
        end
        pending = frame_bytes_due.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AT command frame builder testbench
// Drives payload bytes through the frame builder with random bursts and gaps,
// pops frame bytes under a changing stall pattern, and lets the checker
// compare every frame byte against its own prediction. The start delimiter is
// rewritten between phases, including its lowest and highest values.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_PERIOD   = 20;
    localparam int RANDOM_ITEMS = 114;
    localparam int LONG_HOLD    = 80;   // cycles the receiver refuses to pop
    localparam int IDLE_LIMIT   = 2000; // cycles without any transaction
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {POP_ALWAYS, POP_RANDOM, POP_SPARSE} pop_mode_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [7:0]  cfg_data;
    logic        push;
    logic        full;
    logic [7:0]  payload_byte;
    logic        first_of_frame;
    logic        last_of_frame;
    logic [15:0] payload_length;
    logic        empty;
    logic        pop;
    logic [7:0]  out_byte;
    logic        run_end;
    logic        frame_end;

    int fail_count;
    int pending;
    int bytes_in;
    int bytes_out;
    int checksums;

    // Sender bookkeeping. burst_left counts the transactions still offered
    // back to back before the sender takes a random gap.
    int   burst_left;
    int   frames_sent;
    int   delimiter_writes;
    logic hold_request;

    at_command_frame_builder DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .payload_byte   (payload_byte),
        .first_of_frame (first_of_frame),
        .last_of_frame  (last_of_frame),
        .payload_length (payload_length),
        .empty          (empty),
        .pop            (pop),
        .out_byte       (out_byte),
        .run_end        (run_end),
        .frame_end      (frame_end)
    );

    at_frame_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .payload_byte   (payload_byte),
        .first_of_frame (first_of_frame),
        .last_of_frame  (last_of_frame),
        .payload_length (payload_length),
        .empty          (empty),
        .pop            (pop),
        .out_byte       (out_byte),
        .run_end        (run_end),
        .frame_end      (frame_end),
        .fail_count     (fail_count),
        .pending        (pending),
        .bytes_in       (bytes_in),
        .bytes_out      (bytes_out),
        .checksums      (checksums)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Offers one payload byte and returns at the falling edge after it was
    // accepted. When a burst runs out, the sender first drops push for a
    // random gap, so gaps land on header, payload and checksum phases alike.
    // Push stays high between back-to-back transactions.
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                             input logic [15:0] len);
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        payload_byte   <= b;
        first_of_frame <= first;
        last_of_frame  <= last;
        payload_length <= len;
        push           <= 1'b1;
        do
            @(posedge clk);
        while (full);
        if (first)
            frames_sent++;
        @(negedge clk);
    endtask

    // The delimiter is only rewritten once every predicted byte has been
    // popped. Each input causes at least one result and the last one carries
    // run_end, so an empty prediction store means the block is idle.
    task automatic write_delimiter(input logic [7:0] value);
        push <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        delimiter_writes++;
    endtask

    // Mostly well-formed frames of a few bytes with random content, so that
    // the frame id rolls past Z. The rest is noise: bytes with random marks.
    task automatic random_traffic(input int count);
        int sent;
        int n;
        logic [15:0] len;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                n = $urandom_range(1, 6);
                // The length field is trusted, so now and then it lies.
                if ($urandom_range(0, 9) == 0)
                    len = 16'($urandom_range(1, 65535));
                else
                    len = 16'(n);
                for (int i = 0; i < n; i++)
                    send_byte(8'($urandom_range(0, 255)), i == 0, i == n - 1, len);
                sent += n;
            end
            else
            begin
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 16'($urandom_range(1, 65535)));
                sent++;
            end
        end
    endtask

    // Receiver: picks a new random pop pattern whenever the current one runs out
    // and honors a request from the stimulus for one long hold-off. The decision
    // is taken at the rising edge and applied at the next falling edge.
    initial
    begin : receiver
        pop_mode_t mode;
        int        mode_left;
        int        hold_left;
        int        phase;
        logic      next_pop;
        pop       = 1'b0;
        mode      = POP_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        phase     = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode      = pop_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                next_pop = 1'b0;
            end
            else
            begin
                case (mode)
                    POP_ALWAYS: next_pop = 1'b1;
                    POP_RANDOM: next_pop = 1'($urandom_range(0, 1));
                    default:    next_pop = (phase % 4) == 0;
                endcase
            end
            @(negedge clk);
            pop <= next_pop;
        end
    end

    // Watchdog: a correct run never goes this long without a transaction on
    // either side, even through the long hold-off.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d bytes still due",
                         IDLE_LIMIT, pending);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_write        = 1'b0;
        cfg_data         = 8'h00;
        push             = 1'b0;
        payload_byte     = 8'h00;
        first_of_frame   = 1'b0;
        last_of_frame    = 1'b0;
        payload_length   = 16'h0000;
        hold_request     = 1'b0;
        burst_left       = 0;
        frames_sent      = 0;
        delimiter_writes = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Lowest delimiter. A single-byte frame right after reset takes the
        // frame id from its out-of-range reset value to A.
        write_delimiter(8'h00);
        send_byte(8'h00, 1'b1, 1'b1, 16'd1);
        // Command name plus value at the largest nominal length.
        send_byte("I", 1'b1, 1'b0, 16'd65533);
        send_byte("D", 1'b0, 1'b0, 16'd65533);
        send_byte(8'hFF, 1'b0, 1'b1, 16'd65533);

        // Highest delimiter. Lengths whose header value wraps past 16 bits.
        write_delimiter(8'hFF);
        send_byte(8'hA5, 1'b1, 1'b0, 16'hFFFF);
        send_byte(8'h5A, 1'b0, 1'b1, 16'hFFFF);
        send_byte(8'h3C, 1'b1, 1'b1, 16'hFFFE);
        // Bytes outside any frame still pass through and feed the sum.
        send_byte(8'hFF, 1'b0, 1'b0, 16'h0000);
        send_byte(8'h01, 1'b0, 1'b0, 16'hFFFF);
        // A closing byte with no opening byte before it.
        send_byte(8'h80, 1'b0, 1'b1, 16'h1234);
        // A new frame opened before the previous one closed.
        send_byte(8'h41, 1'b1, 1'b0, 16'd3);
        send_byte(8'h54, 1'b1, 1'b0, 16'd2);
        send_byte(8'h7F, 1'b0, 1'b1, 16'd2);
        // Single-byte frames with lengths that toggle the high and low halves.
        send_byte(8'h55, 1'b1, 1'b1, 16'h8000);
        send_byte(8'hAA, 1'b1, 1'b1, 16'h00FF);
        send_byte(8'h0F, 1'b1, 1'b1, 16'h0100);

        // Back to the usual delimiter for the first random phase.
        write_delimiter(atcfb_pkg::DELIM_RESET);
        random_traffic(RANDOM_ITEMS / 2);

        // The sender pauses until every frame byte is out, then a random
        // delimiter is set.
        write_delimiter(8'($urandom_range(0, 255)));

        // Long hold-off on the result side while the sender keeps pushing
        // back to back, so the queue fills and full must throttle the input.
        hold_request = 1'b1;
        burst_left   = 30;
        random_traffic(RANDOM_ITEMS - RANDOM_ITEMS / 2);

        push <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d payload bytes (%0d frame openings), %0d frame bytes checked",
                 bytes_in, frames_sent, bytes_out);
        $display("covered %0d checksums, %0d delimiter settings, one %0d-cycle pop hold-off",
                 checksums, delimiter_writes, LONG_HOLD);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
